[hdl/dsc_pkg.sv]
// Shared types and constants for the source-chain DMA channel.
// No dependencies; imported by every module of the channel.
package dsc_pkg;

    localparam int STACK_DEPTH = 2;   // call stack slots, 1 to 3
    localparam int Q_DEPTH     = 2;   // item queue between front and back
    localparam int Q_PTR_W     = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

    // item operation, as classified by the front end
    localparam logic [1:0] OP_STEP  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    // register indexes
    localparam logic [2:0] REG_CTRL   = 3'd0;
    localparam logic [2:0] REG_MADR   = 3'd1;
    localparam logic [2:0] REG_QWC    = 3'd2;
    localparam logic [2:0] REG_TADR   = 3'd3;
    localparam logic [2:0] REG_SAVE0  = 3'd4;
    localparam logic [2:0] REG_SAVE1  = 3'd5;
    localparam logic [2:0] REG_STALL  = 3'd6;
    localparam logic [2:0] REG_STATUS = 3'd7;

    // tag ids
    localparam logic [2:0] ID_REFE = 3'd0;
    localparam logic [2:0] ID_CNT  = 3'd1;
    localparam logic [2:0] ID_NEXT = 3'd2;
    localparam logic [2:0] ID_REF  = 3'd3;
    localparam logic [2:0] ID_REFS = 3'd4;
    localparam logic [2:0] ID_CALL = 3'd5;
    localparam logic [2:0] ID_RET  = 3'd6;
    localparam logic [2:0] ID_END  = 3'd7;

    // result kinds
    localparam logic [2:0] K_NONE = 3'd0;
    localparam logic [2:0] K_XFER = 3'd1;
    localparam logic [2:0] K_DONE = 3'd2;
    localparam logic [2:0] K_READ = 3'd3;
    localparam logic [2:0] K_OVF  = 3'd4;

    localparam int         STR_BIT   = 8;
    localparam int         ERR_BIT   = 13;
    localparam logic [1:0] MOD_CHAIN = 2'd1;
    localparam logic [31:0] QW_BYTES = 32'h10;
    localparam logic [31:0] HI_MASK  = 32'hffff0000;
    localparam logic [31:0] LO_MASK  = 32'h0000ffff;

    typedef struct packed {
        logic [1:0]  op;
        logic [2:0]  idx;
        logic [31:0] data;
        logic [15:0] tag_hi;    // upper half of the low tag word, latched into control
        logic [2:0]  tag_id;
        logic [15:0] tag_cnt;
        logic [31:0] tag_addr;
    } t_item;

endpackage

[hdl/dsc_front.sv]
// Front end: classifies an incoming item and splits the tag into its fields.
// Depends on dsc_pkg.
module dsc_front (
    input  logic [1:0]     i_mode,
    input  logic [2:0]     i_reg_index,
    input  logic [31:0]    i_write_data,
    input  logic [63:0]    i_tag_word,
    output dsc_pkg::t_item o_item
);
    import dsc_pkg::*;

    always_comb begin
        o_item = '0;
        case (i_mode)
            OP_STEP:  o_item.op = OP_STEP;
            OP_WRITE: o_item.op = OP_WRITE;
            OP_READ:  o_item.op = OP_READ;
            default:  o_item.op = OP_NONE;
        endcase
        o_item.idx      = i_reg_index;
        o_item.data     = i_write_data;
        o_item.tag_hi   = i_tag_word[31:16];
        o_item.tag_id   = i_tag_word[30:28];
        o_item.tag_cnt  = i_tag_word[15:0];
        o_item.tag_addr = i_tag_word[63:32];
    end

endmodule

[hdl/dsc_queue.sv]
// Short item queue decoupling the front end from the execution back end.
// Depends on dsc_pkg.
module dsc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  dsc_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output dsc_pkg::t_item o_item
);
    import dsc_pkg::*;

    t_item               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]  r_wr, r_rd;
    logic [Q_CNT_W-1:0]  r_cnt;
    logic                do_push, do_pop;

    assign o_full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    function automatic logic [Q_PTR_W-1:0] ptr_inc(input logic [Q_PTR_W-1:0] p);
        ptr_inc = (p == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= ptr_inc(r_wr);
            if (do_pop)  r_rd <= ptr_inc(r_rd);
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= Q_CNT_W'(Q_DEPTH))
        else $error("queue count overrun");
    a_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_full && !do_pop) |=> o_full)
        else $error("full queue lost an entry");
    a_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_valid && !do_push) |=> !o_valid)
        else $error("empty queue produced an item");

endmodule

[hdl/dsc_back.sv]
// Back end: channel registers, tag decode, call stack and the result register.
// Depends on dsc_pkg.
module dsc_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  dsc_pkg::t_item i_item,
    output logic           o_pop,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic [2:0]     o_kind,
    output logic [31:0]    o_transfer_address,
    output logic [31:0]    o_read_data,
    output logic [31:0]    o_next_tag_address,
    output logic           o_running
);
    import dsc_pkg::*;

    logic [31:0] r_ctrl, r_mem_adr, r_tag_adr, r_stall, r_status;
    logic [15:0] r_qwc;
    logic [31:0] r_save [STACK_DEPTH];
    logic        r_tag_taken, r_chain_end;

    logic [31:0] n_ctrl, n_mem_adr, n_tag_adr, n_stall, n_status;
    logic [15:0] n_qwc;
    logic [31:0] n_save [STACK_DEPTH];
    logic        n_tag_taken, n_chain_end;

    logic        r_out_valid;
    logic [2:0]  r_kind;
    logic [31:0] r_xfer, r_rd;
    logic [2:0]  n_kind;
    logic [31:0] n_xfer, n_rd;

    logic        load, active, stack_full;
    logic [1:0]  asp, asp_m1;
    logic [31:0] follow, data_base, pop_val;

    assign load   = i_q_valid && (!r_out_valid || i_out_ready);
    assign o_pop  = load;
    assign asp    = r_ctrl[5:4];
    assign asp_m1 = asp - 2'd1;
    assign active = r_ctrl[STR_BIT] && (r_ctrl[3:2] == MOD_CHAIN);
    assign stack_full = ({1'b0, asp} >= 3'(STACK_DEPTH)) || (asp == 2'd3);
    assign follow = r_tag_adr + QW_BYTES;

    always_comb begin
        pop_val = '0;
        for (int k = 0; k < STACK_DEPTH; k++) begin
            if (asp_m1 == 2'(k)) pop_val = r_save[k];
        end
    end

    always_comb begin
        n_ctrl      = r_ctrl;
        n_mem_adr   = r_mem_adr;
        n_tag_adr   = r_tag_adr;
        n_stall     = r_stall;
        n_status    = r_status;
        n_qwc       = r_qwc;
        n_save      = r_save;
        n_tag_taken = r_tag_taken;
        n_chain_end = r_chain_end;
        n_kind      = K_NONE;
        n_xfer      = '0;
        n_rd        = '0;
        data_base   = follow;
        case (i_item.op)
            OP_STEP: begin
                if (active) begin
                    if (r_qwc != '0) begin
                        n_kind    = K_XFER;
                        n_xfer    = r_mem_adr;
                        n_mem_adr = r_mem_adr + QW_BYTES;
                        n_qwc     = r_qwc - 16'd1;
                    end else if (r_tag_taken && r_chain_end) begin
                        n_ctrl[STR_BIT] = 1'b0;
                        n_tag_taken     = 1'b0;
                        n_chain_end     = 1'b0;
                        n_kind          = K_DONE;
                    end else begin
                        n_ctrl[31:16] = i_item.tag_hi;
                        if (i_item.tag_id == ID_CALL && stack_full) begin
                            n_ctrl[STR_BIT]   = 1'b0;
                            n_tag_taken       = 1'b0;
                            n_chain_end       = 1'b0;
                            n_status[ERR_BIT] = 1'b1;
                            n_kind            = K_OVF;
                        end else begin
                            n_tag_taken = 1'b1;
                            n_chain_end = 1'b0;
                            case (i_item.tag_id)
                                ID_REFE: begin
                                    data_base   = i_item.tag_addr;
                                    n_tag_adr   = follow;
                                    n_chain_end = 1'b1;
                                end
                                ID_CNT: begin
                                    n_tag_adr = follow + {12'd0, i_item.tag_cnt, 4'd0};
                                end
                                ID_NEXT: begin
                                    n_tag_adr = i_item.tag_addr;
                                end
                                ID_REF, ID_REFS: begin
                                    data_base = i_item.tag_addr;
                                    n_tag_adr = follow;
                                end
                                ID_CALL: begin
                                    for (int k = 0; k < STACK_DEPTH; k++) begin
                                        if (asp == 2'(k)) begin
                                            n_save[k] = follow + {12'd0, i_item.tag_cnt, 4'd0};
                                        end
                                    end
                                    n_tag_adr   = i_item.tag_addr;
                                    n_ctrl[5:4] = asp + 2'd1;
                                end
                                ID_RET: begin
                                    if (asp != 2'd0) begin
                                        n_ctrl[5:4] = asp_m1;
                                        n_tag_adr   = pop_val;
                                    end else begin
                                        n_chain_end = 1'b1;
                                    end
                                end
                                default: begin
                                    n_chain_end = 1'b1;
                                end
                            endcase
                            // a tag with data moves its first quadword at once
                            if (i_item.tag_cnt != '0) begin
                                n_kind    = K_XFER;
                                n_xfer    = data_base;
                                n_mem_adr = data_base + QW_BYTES;
                                n_qwc     = i_item.tag_cnt - 16'd1;
                            end else begin
                                n_mem_adr = data_base;
                                n_qwc     = '0;
                            end
                        end
                    end
                end
            end
            OP_WRITE: begin
                case (i_item.idx)
                    REG_CTRL: begin
                        n_ctrl      = i_item.data;
                        n_tag_taken = 1'b0;
                        n_chain_end = 1'b0;
                    end
                    REG_MADR:  n_mem_adr = i_item.data;
                    REG_QWC:   n_qwc     = i_item.data[15:0];
                    REG_TADR:  n_tag_adr = i_item.data;
                    REG_SAVE0, REG_SAVE1: begin
                        for (int k = 0; k < STACK_DEPTH; k++) begin
                            if ((k == 0 && i_item.idx == REG_SAVE0) ||
                                (k == 1 && i_item.idx == REG_SAVE1)) begin
                                n_save[k] = i_item.data;
                            end
                        end
                    end
                    REG_STALL: n_stall = i_item.data;
                    default: begin
                        // low half clears where set, high half toggles where set
                        n_status = (r_status ^ (i_item.data & HI_MASK)) &
                                   ~(i_item.data & LO_MASK);
                    end
                endcase
            end
            OP_READ: begin
                n_kind = K_READ;
                case (i_item.idx)
                    REG_CTRL:   n_rd = r_ctrl;
                    REG_QWC:    n_rd = {16'd0, r_qwc};
                    REG_TADR:   n_rd = r_tag_adr;
                    REG_STATUS: n_rd = r_status;
                    default:    n_rd = '0;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl      <= '0;
            r_mem_adr   <= '0;
            r_tag_adr   <= '0;
            r_stall     <= '0;
            r_status    <= '0;
            r_qwc       <= '0;
            r_save      <= '{default: '0};
            r_tag_taken <= 1'b0;
            r_chain_end <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_ctrl      <= n_ctrl;
                r_mem_adr   <= n_mem_adr;
                r_tag_adr   <= n_tag_adr;
                r_stall     <= n_stall;
                r_status    <= n_status;
                r_qwc       <= n_qwc;
                r_save      <= n_save;
                r_tag_taken <= n_tag_taken;
                r_chain_end <= n_chain_end;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind <= n_kind;
            r_xfer <= n_xfer;
            r_rd   <= n_rd;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_kind             = r_kind;
    assign o_transfer_address = r_xfer;
    assign o_read_data        = r_rd;
    assign o_next_tag_address = r_tag_adr;
    assign o_running          = r_ctrl[STR_BIT];

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !load)
        else $error("result overwritten while stalled");
    a_done_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && n_kind == K_DONE) |=> (!r_ctrl[STR_BIT] && !r_tag_taken && !r_chain_end))
        else $error("chain end left the channel running");
    a_ovf_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && n_kind == K_OVF) |=> (r_status[ERR_BIT] && !r_ctrl[STR_BIT]))
        else $error("stack overflow not flagged");
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !load |=> ($stable(r_tag_adr) && $stable(r_qwc) && $stable(r_ctrl)))
        else $error("channel state moved without an item");

endmodule

[hdl/dma_source_chain_channel.sv]
// Single source-chain DMA channel: accepts one item per cycle (step, register write or
// register read) unless the queue is full, and returns exactly one result per item.
// Items are decoded in a front end, held in a two-entry queue, and executed by a back
// end that updates all channel registers and the call stack, so the sustained rate is
// one item per clock while results are taken; an item passes through the queue and the
// result register. A running step with zero quadword count ends the chain if the last
// tag ended it, else decodes the supplied tag and, if it carries data, moves its first
// quadword in the same item. Depends on dsc_pkg, dsc_front, dsc_queue and dsc_back.
module dma_source_chain_channel (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_mode,
    input  logic [2:0]  i_reg_index,
    input  logic [31:0] i_write_data,
    input  logic [63:0] i_tag_word,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_kind,
    output logic [31:0] o_transfer_address,
    output logic [31:0] o_read_data,
    output logic [31:0] o_next_tag_address,
    output logic        o_running
);
    import dsc_pkg::*;

    t_item dec_item, q_item;
    logic  q_full, q_valid, q_pop;

    assign o_in_ready = !q_full;

    dsc_front u_front (
        .i_mode       (i_mode),
        .i_reg_index  (i_reg_index),
        .i_write_data (i_write_data),
        .i_tag_word   (i_tag_word),
        .o_item       (dec_item)
    );

    dsc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in_valid),
        .i_item  (dec_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    dsc_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_q_valid          (q_valid),
        .i_item             (q_item),
        .o_pop              (q_pop),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_kind             (o_kind),
        .o_transfer_address (o_transfer_address),
        .o_read_data        (o_read_data),
        .o_next_tag_address (o_next_tag_address),
        .o_running          (o_running)
    );

endmodule
